// ===== rtl/tlh_pkg.sv =====
// tlh_pkg: shared constants, result kinds and the control/status structs
// that join the controller and the datapath of the two-level huffman codec
// no dependencies
package tlh_pkg;

  // fixed code geometry
  localparam int MAX_CODE_LENGTH  = 16;
  localparam int FIRST_LEVEL_BITS = 8;
  localparam int SLOTS            = 256;
  localparam int DEFAULT_TABLES   = 16;

  // field widths
  localparam int CODE_W = 16;
  localparam int LEN_W  = 5;
  localparam int SYM_W  = 8;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // item commands
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_DECODE = 2'd1;
  localparam logic [1:0] CMD_ENCODE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  // what the result register is loaded with
  typedef enum logic [2:0] {
    RES_LOAD_OK,
    RES_INVALID,
    RES_POOL_FULL,
    RES_DECODE,
    RES_ENCODE
  } res_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      fl_read;
    logic      sl_read;
    logic      enc_read;
    logic      sweep_start;
    logic      sweep_alloc;
    logic      sweep_step;
    logic      enc_write;
    logic      result_load;
    res_kind_t kind;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       len_bad;
    logic       is_short;
    logic       link_zero;
    logic       pool_full;
    logic       sweep_last;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== rtl/tlh_ctrl.sv =====
// tlh_ctrl: sequencing state machine of the huffman table codec
// depends on tlh_pkg for the command/status structs and codes
module tlh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tlh_pkg::dp_status_t stat,
  output tlh_pkg::ctrl_cmd_t  ctl
);
  import tlh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LONG,
    S_SWEEP,
    S_DECODE,
    S_FINISH
  } state_t;

  state_t    state, state_next;
  res_kind_t kind, kind_next;

  // one item in flight at a time
  assign in_stall = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    ctl        = '0;
    ctl.kind   = kind;
    state_next = state;
    kind_next  = kind;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat.cmd == CMD_LOAD && stat.len_bad) begin
          kind_next  = RES_INVALID;
          state_next = S_FINISH;
        end else if (stat.cmd == CMD_LOAD && stat.is_short) begin
          ctl.sweep_start = 1'b1;
          state_next      = S_SWEEP;
        end else if (stat.cmd == CMD_LOAD) begin
          ctl.fl_read = 1'b1;
          state_next  = S_LONG;
        end else if (stat.cmd == CMD_DECODE) begin
          ctl.fl_read = 1'b1;
          state_next  = S_DECODE;
        end else if (stat.cmd == CMD_ENCODE) begin
          ctl.enc_read = 1'b1;
          kind_next    = RES_ENCODE;
          state_next   = S_FINISH;
        end else begin
          kind_next  = RES_INVALID;
          state_next = S_FINISH;
        end
      end
      // long code: first-level slot of the prefix has been read
      S_LONG: begin
        priority if (!stat.link_zero) begin
          ctl.sweep_start = 1'b1;
          state_next      = S_SWEEP;
        end else if (stat.pool_full) begin
          kind_next  = RES_POOL_FULL;
          state_next = S_FINISH;
        end else begin
          ctl.sweep_alloc = 1'b1;
          state_next      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          kind_next  = RES_LOAD_OK;
          state_next = S_FINISH;
        end
      end
      // follow the link into the second level when there is one
      S_DECODE: begin
        ctl.sl_read = !stat.link_zero;
        kind_next   = RES_DECODE;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.result_load = 1'b1;
          ctl.enc_write   = (kind == RES_LOAD_OK);
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered result kind
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= RES_INVALID;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

// ===== rtl/tlh_datapath.sv =====
// tlh_datapath: table memories, fill sweep, table pool and result register
// depends on tlh_pkg; driven by tlh_ctrl through ctrl_cmd_t
module tlh_datapath #(
  parameter int Tables = tlh_pkg::DEFAULT_TABLES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 command,
  input  logic [tlh_pkg::CODE_W-1:0] code_bits,
  input  logic [tlh_pkg::LEN_W-1:0]  code_length,
  input  logic [tlh_pkg::SYM_W-1:0]  symbol,
  input  logic [tlh_pkg::CODE_W-1:0] window,
  input  logic                       out_stall,
  input  tlh_pkg::ctrl_cmd_t         ctl,
  output tlh_pkg::dp_status_t        stat,
  output logic                       out_valid,
  output logic [tlh_pkg::SYM_W-1:0]  symbol_out,
  output logic [tlh_pkg::CODE_W-1:0] code_out,
  output logic [tlh_pkg::LEN_W-1:0]  length_out,
  output logic [1:0]                 status
);
  import tlh_pkg::*;

  localparam int LW       = $clog2(Tables + 1);
  localparam int TW       = (Tables > 1) ? $clog2(Tables) : 1;
  localparam int SL_DEPTH = Tables * SLOTS;
  localparam int SL_AW    = TW + FIRST_LEVEL_BITS;
  localparam int FL_W     = LEN_W + SYM_W + LW;
  localparam int SL_W     = LEN_W + SYM_W;
  localparam int ENC_W    = CODE_W + LEN_W;

  // captured item
  logic [1:0]        cmd_q;
  logic [CODE_W-1:0] code_q;
  logic [LEN_W-1:0]  len_q;
  logic [SYM_W-1:0]  sym_q;
  logic [CODE_W-1:0] win_q;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q  <= command;
      code_q <= code_bits;
      len_q  <= code_length;
      sym_q  <= symbol;
      win_q  <= window;
    end
  end

  // code geometry from the captured load
  logic              len_bad, is_short;
  logic [LEN_W-1:0]  drop, sh_short, up;
  logic [CODE_W-1:0] code_m, shl_short, shr_long, shl_long;
  logic [7:0]        base_short, mask_short, top_long, base_long, mask_long;

  always_comb begin
    len_bad    = (len_q == '0) || (len_q > LEN_W'(MAX_CODE_LENGTH));
    is_short   = (len_q <= LEN_W'(FIRST_LEVEL_BITS));
    drop       = LEN_W'(MAX_CODE_LENGTH) - len_q;
    code_m     = code_q & ({CODE_W{1'b1}} >> drop);
    sh_short   = LEN_W'(FIRST_LEVEL_BITS) - len_q;
    shl_short  = code_m << sh_short;
    base_short = shl_short[7:0];
    mask_short = BYTE_MASK >> len_q;
    up         = len_q - LEN_W'(FIRST_LEVEL_BITS);
    shr_long   = code_m >> up;
    top_long   = shr_long[7:0];
    shl_long   = code_m << drop;
    base_long  = shl_long[7:0];
    mask_long  = BYTE_MASK >> up;
  end

  // table pool
  logic [LW-1:0] used;
  logic          pool_full;

  assign pool_full = (used >= LW'(Tables));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctl.sweep_alloc) begin
      used <= used + LW'(1);
    end
  end

  // first-level table: {length, symbol, link}, valid bit per slot
  logic [FL_W-1:0]  fl_mem [SLOTS];
  logic [SLOTS-1:0] fl_valid;
  logic [FL_W-1:0]  fl_rd;
  logic [7:0]       fl_raddr, fl_waddr;
  logic [FL_W-1:0]  fl_wdata;
  logic             fl_we;
  logic [LEN_W-1:0] fl_rd_len;
  logic [SYM_W-1:0] fl_rd_sym;
  logic [LW-1:0]    fl_rd_link, link_m1, used_p1;
  logic [TW-1:0]    link_tbl;

  assign fl_rd_len  = fl_rd[FL_W-1 -: LEN_W];
  assign fl_rd_sym  = fl_rd[LW +: SYM_W];
  assign fl_rd_link = fl_rd[LW-1:0];
  assign link_m1    = fl_rd_link - LW'(1);
  assign link_tbl   = link_m1[TW-1:0];
  assign used_p1    = used + LW'(1);
  assign fl_raddr   = (cmd_q == CMD_DECODE) ? win_q[15:8] : top_long;

  // sweep over the slots a code covers, or over every slot of a fresh table
  logic       sw_first, sw_full;
  logic [TW-1:0] sw_tbl;
  logic [7:0] sw_i, sw_base, sw_mask, sw_addr;
  logic       sw_covered, sw_last;

  assign sw_addr    = sw_full ? sw_i : (sw_base | sw_i);
  assign sw_covered = ((sw_i & ~sw_mask) == sw_base);
  assign sw_last    = (sw_i == (sw_full ? BYTE_MASK : sw_mask));

  always_ff @(posedge clk) begin
    if (ctl.sweep_start) begin
      sw_first <= is_short;
      sw_full  <= 1'b0;
      sw_tbl   <= link_tbl;
      sw_i     <= '0;
      sw_base  <= is_short ? base_short : base_long;
      sw_mask  <= is_short ? mask_short : mask_long;
    end else if (ctl.sweep_alloc) begin
      sw_first <= 1'b0;
      sw_full  <= 1'b1;
      sw_tbl   <= used[TW-1:0];
      sw_i     <= '0;
      sw_base  <= base_long;
      sw_mask  <= mask_long;
    end else if (ctl.sweep_step) begin
      sw_i <= sw_i + 8'd1;
    end
  end

  // first-level write: short-code fill or link of a fresh table
  assign fl_we    = (ctl.sweep_step && sw_first) || ctl.sweep_alloc;
  assign fl_waddr = ctl.sweep_alloc ? top_long : sw_addr;
  assign fl_wdata = ctl.sweep_alloc ? {fl_rd_len, fl_rd_sym, used_p1}
                                    : {len_q, sym_q, LW'(0)};

  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_waddr] <= fl_wdata;
    end
    if (ctl.fl_read) begin
      fl_rd <= fl_valid[fl_raddr] ? fl_mem[fl_raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_valid <= '0;
    end else if (fl_we) begin
      fl_valid[fl_waddr] <= 1'b1;
    end
  end

  // second-level tables: a fresh table is zeroed by its full sweep
  logic [SL_W-1:0]  sl_mem [SL_DEPTH];
  logic [SL_W-1:0]  sl_rd;
  logic             sl_we;
  logic [SL_AW-1:0] sl_waddr, sl_raddr;
  logic [SL_W-1:0]  sl_wdata;

  assign sl_we    = ctl.sweep_step && !sw_first;
  assign sl_waddr = {sw_tbl, sw_addr};
  assign sl_wdata = (sw_full && !sw_covered) ? '0 : {len_q, sym_q};
  assign sl_raddr = {link_tbl, win_q[7:0]};

  always_ff @(posedge clk) begin
    if (sl_we) begin
      sl_mem[sl_waddr] <= sl_wdata;
    end
    if (ctl.sl_read) begin
      sl_rd <= sl_mem[sl_raddr];
    end
  end

  // encode record: {code, length}, first load of a symbol wins
  logic [ENC_W-1:0] enc_mem [SLOTS];
  logic [SLOTS-1:0] enc_valid;
  logic [ENC_W-1:0] enc_rd;
  logic             enc_rd_valid;
  logic             enc_we;

  assign enc_we = ctl.enc_write && !enc_valid[sym_q];

  always_ff @(posedge clk) begin
    if (enc_we) begin
      enc_mem[sym_q] <= {code_m, len_q};
    end
    if (ctl.enc_read) begin
      enc_rd <= enc_mem[sym_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_valid    <= '0;
      enc_rd_valid <= 1'b0;
    end else begin
      if (enc_we) begin
        enc_valid[sym_q] <= 1'b1;
      end
      if (ctl.enc_read) begin
        enc_rd_valid <= enc_valid[sym_q];
      end
    end
  end

  // result selection
  logic [SYM_W-1:0]  res_sym, dec_sym;
  logic [CODE_W-1:0] res_code;
  logic [LEN_W-1:0]  res_len, dec_len;
  logic [1:0]        res_status;

  always_comb begin
    dec_len    = (fl_rd_link != '0) ? sl_rd[SL_W-1 -: LEN_W] : fl_rd_len;
    dec_sym    = (fl_rd_link != '0) ? sl_rd[SYM_W-1:0] : fl_rd_sym;
    res_sym    = '0;
    res_code   = '0;
    res_len    = '0;
    res_status = ST_ABSENT;
    unique case (ctl.kind)
      RES_LOAD_OK:   res_status = ST_OK;
      RES_INVALID:   res_status = ST_ABSENT;
      RES_POOL_FULL: res_status = ST_POOL_FULL;
      RES_DECODE: begin
        if (dec_len != '0) begin
          res_sym    = dec_sym;
          res_len    = dec_len;
          res_status = ST_OK;
        end
      end
      RES_ENCODE: begin
        if (enc_rd_valid) begin
          res_code   = enc_rd[ENC_W-1 -: CODE_W];
          res_len    = enc_rd[LEN_W-1:0];
          res_status = ST_OK;
        end
      end
      default: res_status = ST_ABSENT;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.result_load) begin
      symbol_out <= res_sym;
      code_out   <= res_code;
      length_out <= res_len;
      status     <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // status to the controller
  always_comb begin
    stat.cmd        = cmd_q;
    stat.len_bad    = len_bad;
    stat.is_short   = is_short;
    stat.link_zero  = (fl_rd_link == '0);
    stat.pool_full  = pool_full;
    stat.sweep_last = sw_last;
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/two_level_huffman_table_codec.sv =====
// two_level_huffman_table_codec: top level of the two-level huffman code table
// depends on tlh_pkg, tlh_ctrl and tlh_datapath
//
//   channel  handshake              fields
//   in       in_valid / in_stall    command, code_bits, code_length, symbol, window
//   out      out_valid / out_stall  symbol_out, code_out, length_out, status
//
// one item at a time; steps from accept to result register loaded:
//   encode reads the encode record; decode the first level, then the second level
//   when the slot links one; a short load sweeps its first-level slots; a long load
//   sweeps its second-level slots, all 256 of a fresh table (one slot a cycle)
// reset clears first-level and encode valid bits, the pool count and control
// a result held by out_stall stays put; the next item waits in its last step
module two_level_huffman_table_codec #(
  parameter int SECOND_LEVEL_TABLES = tlh_pkg::DEFAULT_TABLES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 command,
  input  logic [tlh_pkg::CODE_W-1:0] code_bits,
  input  logic [tlh_pkg::LEN_W-1:0]  code_length,
  input  logic [tlh_pkg::SYM_W-1:0]  symbol,
  input  logic [tlh_pkg::CODE_W-1:0] window,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tlh_pkg::SYM_W-1:0]  symbol_out,
  output logic [tlh_pkg::CODE_W-1:0] code_out,
  output logic [tlh_pkg::LEN_W-1:0]  length_out,
  output logic [1:0]                 status
);
  import tlh_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t stat;

  tlh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  tlh_datapath #(
    .Tables (SECOND_LEVEL_TABLES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .code_bits   (code_bits),
    .code_length (code_length),
    .symbol      (symbol),
    .window      (window),
    .out_stall   (out_stall),
    .ctl         (ctl),
    .stat        (stat),
    .out_valid   (out_valid),
    .symbol_out  (symbol_out),
    .code_out    (code_out),
    .length_out  (length_out),
    .status      (status)
  );

endmodule

// ===== sim/tlh_codec_checker.sv =====
// tlh_codec_checker: watches both channels of the huffman table codec, predicts each
// result from its own copy of the code tables and compares field by field
// depends on tlh_pkg
module tlh_codec_checker #(
  parameter int NUM_TABLES = tlh_pkg::DEFAULT_TABLES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 command,
  input  logic [tlh_pkg::CODE_W-1:0] code_bits,
  input  logic [tlh_pkg::LEN_W-1:0]  code_length,
  input  logic [tlh_pkg::SYM_W-1:0]  symbol,
  input  logic [tlh_pkg::CODE_W-1:0] window,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [tlh_pkg::SYM_W-1:0]  symbol_out,
  input  logic [tlh_pkg::CODE_W-1:0] code_out,
  input  logic [tlh_pkg::LEN_W-1:0]  length_out,
  input  logic [1:0]                 status,
  output int                         fail_count,
  output int                         pending,
  output int                         results_checked,
  output int                         pool_full_seen
);
  import tlh_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [1:0]        st;
  } table_result_t;

  // predicted code tables
  logic [LEN_W-1:0]  fl_len  [SLOTS];
  logic [SYM_W-1:0]  fl_sym  [SLOTS];
  logic [8:0]        fl_link [SLOTS];
  logic [LEN_W-1:0]  sl_len  [NUM_TABLES*SLOTS];
  logic [SYM_W-1:0]  sl_sym  [NUM_TABLES*SLOTS];
  logic [CODE_W-1:0] enc_code [SLOTS];
  logic [LEN_W-1:0]  enc_len  [SLOTS];
  int                tables_used;

  table_result_t awaited_results[$];

  function automatic table_result_t pack_result(logic [SYM_W-1:0] s, logic [CODE_W-1:0] c,
                                                logic [LEN_W-1:0] l, logic [1:0] st);
    table_result_t r;
    r.sym  = s;
    r.code = c;
    r.len  = l;
    r.st   = st;
    return r;
  endfunction

  // enter one code into the tables, returns the load status
  function automatic logic [1:0] enter_code(logic [CODE_W-1:0] cb, logic [LEN_W-1:0] len,
                                            logic [SYM_W-1:0] sym);
    int unsigned code_val;
    int unsigned base;
    int unsigned span;
    int unsigned top;
    int unsigned tbl;
    if (len == 0 || len > MAX_CODE_LENGTH) return ST_ABSENT;
    code_val = 32'(cb) & ((32'd1 << len) - 32'd1);
    if (len <= FIRST_LEVEL_BITS) begin
      base = (code_val << (FIRST_LEVEL_BITS - len)) & 32'(BYTE_MASK);
      span = 32'd1 << (FIRST_LEVEL_BITS - len);
      for (int unsigned i = 0; i < span; i++) begin
        fl_len[(base | i) & 32'hFF]  = len;
        fl_sym[(base | i) & 32'hFF]  = sym;
        fl_link[(base | i) & 32'hFF] = '0;
      end
    end else begin
      top = (code_val >> (len - FIRST_LEVEL_BITS)) & 32'(BYTE_MASK);
      if (fl_link[top] == 0) begin
        // a fresh second-level table, or nothing at all when the pool is spent
        if (tables_used >= NUM_TABLES) return ST_POOL_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          sl_len[tables_used*SLOTS + i] = '0;
          sl_sym[tables_used*SLOTS + i] = '0;
        end
        tables_used++;
        fl_link[top] = 9'(tables_used);
      end
      tbl = 32'(fl_link[top]) - 1;
      if (tbl >= NUM_TABLES) tbl = 0;
      base = (code_val << (MAX_CODE_LENGTH - len)) & 32'(BYTE_MASK);
      span = 32'd1 << (MAX_CODE_LENGTH - len);
      for (int unsigned i = 0; i < span; i++) begin
        sl_len[tbl*SLOTS + ((base | i) & 32'hFF)] = len;
        sl_sym[tbl*SLOTS + ((base | i) & 32'hFF)] = sym;
      end
    end
    // first load of a symbol keeps its encode record
    if (enc_len[sym] == 0) begin
      enc_code[sym] = CODE_W'(code_val);
      enc_len[sym]  = len;
    end
    return ST_OK;
  endfunction

  // expected result of one accepted item, with its effect on the tables
  function automatic table_result_t predict_table_result(logic [1:0] cmd,
      logic [CODE_W-1:0] cb, logic [LEN_W-1:0] len, logic [SYM_W-1:0] sym,
      logic [CODE_W-1:0] win);
    logic [LEN_W-1:0] l;
    logic [SYM_W-1:0] s;
    int unsigned      tbl;
    case (cmd)
      CMD_LOAD: begin
        return pack_result('0, '0, '0, enter_code(cb, len, sym));
      end
      CMD_DECODE: begin
        if (fl_link[win[15:8]] == 0) begin
          l = fl_len[win[15:8]];
          s = fl_sym[win[15:8]];
        end else begin
          tbl = 32'(fl_link[win[15:8]]) - 1;
          if (tbl >= NUM_TABLES) tbl = 0;
          l = sl_len[tbl*SLOTS + 32'(win[7:0])];
          s = sl_sym[tbl*SLOTS + 32'(win[7:0])];
        end
        if (l == 0) return pack_result('0, '0, '0, ST_ABSENT);
        return pack_result(s, '0, l, ST_OK);
      end
      CMD_ENCODE: begin
        if (enc_len[sym] == 0) return pack_result('0, '0, '0, ST_ABSENT);
        return pack_result('0, enc_code[sym], enc_len[sym], ST_OK);
      end
      default: begin
        return pack_result('0, '0, '0, ST_ABSENT);
      end
    endcase
  endfunction

  // compare results first, then queue the expectation of a newly taken item
  always @(posedge clk) begin : watch_channels
    table_result_t got;
    table_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        fl_len[i]   = '0;
        fl_sym[i]   = '0;
        fl_link[i]  = '0;
        enc_code[i] = '0;
        enc_len[i]  = '0;
      end
      for (int i = 0; i < NUM_TABLES*SLOTS; i++) begin
        sl_len[i] = '0;
        sl_sym[i] = '0;
      end
      tables_used = 0;
      awaited_results.delete();
      fail_count      = 0;
      results_checked = 0;
      pool_full_seen  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = pack_result(symbol_out, code_out, length_out, status);
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: sym %h code %h len %0d status %0d",
                     got.sym, got.code, got.len, got.st);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (want.st == ST_POOL_FULL) pool_full_seen++;
          if (got.sym != want.sym || got.code != want.code || got.len != want.len ||
              got.st != want.st) begin
            if (fail_count < 10)
              $display("result %0d mismatch: expected sym %h code %h len %0d status %0d, %s",
                       results_checked, want.sym, want.code, want.len, want.st,
                       $sformatf("got sym %h code %h len %0d status %0d",
                                 got.sym, got.code, got.len, got.st));
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(predict_table_result(command, code_bits, code_length,
                                                       symbol, window));
    end
    pending = awaited_results.size();
  end

endmodule

// ===== sim/tb_two_level_huffman_table_codec.sv =====
// tb_two_level_huffman_table_codec: drives loads, decodes and encodes into the
// huffman table codec with random gaps and stalls; verdict from the checker count
// depends on tlh_pkg, tlh_codec_checker and the codec rtl
module tb_two_level_huffman_table_codec;
  import tlh_pkg::*;

  localparam int NUM_TABLES   = DEFAULT_TABLES;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic [1:0]        command = CMD_LOAD;
  logic [CODE_W-1:0] code_bits = '0;
  logic [LEN_W-1:0]  code_length = '0;
  logic [SYM_W-1:0]  symbol = '0;
  logic [CODE_W-1:0] window = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [SYM_W-1:0]  symbol_out;
  logic [CODE_W-1:0] code_out;
  logic [LEN_W-1:0]  length_out;
  logic [1:0]        status;

  int fail_count;
  int pending;
  int results_checked;
  int pool_full_seen;

  // no idling on either side while set
  logic quiet = 1'b0;
  int   cycle_count = 0;
  int   loads_sent = 0;
  int   decodes_sent = 0;
  int   encodes_sent = 0;
  int   others_sent = 0;

  // recently loaded codes, for decode windows and encodes that hit
  logic [CODE_W-1:0] loaded_code[$];
  logic [LEN_W-1:0]  loaded_len[$];
  logic [SYM_W-1:0]  loaded_sym[$];
  logic [7:0]        long_tops[$];

  two_level_huffman_table_codec #(
    .SECOND_LEVEL_TABLES(NUM_TABLES)
  ) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .code_bits(code_bits), .code_length(code_length),
    .symbol(symbol), .window(window),
    .out_valid(out_valid), .out_stall(out_stall),
    .symbol_out(symbol_out), .code_out(code_out), .length_out(length_out),
    .status(status)
  );

  tlh_codec_checker #(
    .NUM_TABLES(NUM_TABLES)
  ) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .code_bits(code_bits), .code_length(code_length),
    .symbol(symbol), .window(window),
    .out_valid(out_valid), .out_stall(out_stall),
    .symbol_out(symbol_out), .code_out(code_out), .length_out(length_out),
    .status(status),
    .fail_count(fail_count), .pending(pending),
    .results_checked(results_checked), .pool_full_seen(pool_full_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 12);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped: limit of %0d cycles reached, %0d results still awaited",
               CYCLE_LIMIT, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // present one item after a random gap and hold it until taken
  task automatic offer_item(input logic [1:0] cmd, input logic [CODE_W-1:0] cb,
                            input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] win);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    code_bits   <= cb;
    code_length <= len;
    symbol      <= sym;
    window      <= win;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (cmd)
      CMD_LOAD:   loads_sent++;
      CMD_DECODE: decodes_sent++;
      CMD_ENCODE: encodes_sent++;
      default:    others_sent++;
    endcase
  endtask

  // load item, remembered for later hits
  task automatic load_code(input logic [CODE_W-1:0] cb, input logic [LEN_W-1:0] len,
                           input logic [SYM_W-1:0] sym);
    int unsigned masked;
    masked = 32'(cb) & ((32'd1 << len) - 32'd1);
    if (len >= 1 && len <= MAX_CODE_LENGTH) begin
      loaded_code.push_back(CODE_W'(masked));
      loaded_len.push_back(len);
      loaded_sym.push_back(sym);
      if (loaded_code.size() > 64) begin
        void'(loaded_code.pop_front());
        void'(loaded_len.pop_front());
        void'(loaded_sym.pop_front());
      end
      if (len > FIRST_LEVEL_BITS) begin
        long_tops.push_back(8'(masked >> (len - FIRST_LEVEL_BITS)));
        if (long_tops.size() > 16) void'(long_tops.pop_front());
      end
    end
    offer_item(CMD_LOAD, cb, len, sym, CODE_W'($urandom));
  endtask

  task automatic decode_window(input logic [CODE_W-1:0] win);
    offer_item(CMD_DECODE, CODE_W'($urandom), LEN_W'($urandom), SYM_W'($urandom), win);
  endtask

  task automatic encode_symbol(input logic [SYM_W-1:0] sym);
    offer_item(CMD_ENCODE, CODE_W'($urandom), LEN_W'($urandom), sym, CODE_W'($urandom));
  endtask

  // one random item: mostly loads and lookups that hit, some noise
  task automatic random_item();
    int unsigned pick;
    int unsigned cb;
    int unsigned len;
    int unsigned k;
    int unsigned low_bits;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      k = $urandom_range(0, 99);
      if (k < 4) len = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
      else if (k < 12) len = $urandom_range(1, 4);
      else if (k < 45) len = $urandom_range(5, 8);
      else len = $urandom_range(9, 16);
      cb = $urandom_range(0, 65535);
      // long codes mostly reuse a top byte that already has a table
      if (len > FIRST_LEVEL_BITS && len <= MAX_CODE_LENGTH && long_tops.size() > 0 &&
          $urandom_range(0, 99) < 70) begin
        low_bits = len - FIRST_LEVEL_BITS;
        cb = (cb & ~((32'd1 << len) - 32'd1)) |
             (32'(long_tops[$urandom_range(0, long_tops.size() - 1)]) << low_bits) |
             (cb & ((32'd1 << low_bits) - 32'd1));
      end
      load_code(CODE_W'(cb), LEN_W'(len), SYM_W'($urandom));
    end else if (pick < 65) begin
      if (loaded_code.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, loaded_code.size() - 1);
        len = loaded_len[k];
        cb = (32'(loaded_code[k]) << (MAX_CODE_LENGTH - len)) |
             ($urandom & ((32'd1 << (MAX_CODE_LENGTH - len)) - 32'd1));
        decode_window(CODE_W'(cb));
      end else begin
        decode_window(CODE_W'($urandom));
      end
    end else if (pick < 92) begin
      if (loaded_sym.size() > 0 && $urandom_range(0, 99) < 60)
        encode_symbol(loaded_sym[$urandom_range(0, loaded_sym.size() - 1)]);
      else
        encode_symbol(SYM_W'($urandom));
    end else begin
      offer_item(CMD_UNUSED, CODE_W'($urandom), LEN_W'($urandom), SYM_W'($urandom),
                 CODE_W'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tables, bad commands and lengths
    decode_window(16'h0000);
    encode_symbol(8'h00);
    offer_item(CMD_UNUSED, 16'hFFFF, 5'd31, 8'hFF, 16'hFFFF);
    load_code(16'h0000, 5'd0, 8'h11);
    load_code(16'hFFFF, 5'd17, 8'h22);
    // one-bit code with junk above its length
    load_code(16'hFFFF, 5'd1, 8'hAA);
    decode_window(16'hFFFF);
    encode_symbol(8'hAA);
    load_code(16'h0000, 5'd8, 8'h00);
    decode_window(16'h00FF);
    // longest code opens a second-level table
    load_code(16'h1234, 5'd16, 8'hFF);
    decode_window(16'h1234);
    decode_window(16'h1235);
    // nine-bit code under a slot already filled by a short code
    load_code(16'h01FF, 5'd9, 8'h01);
    decode_window(16'hFF80);
    decode_window(16'hFF00);
    // short code over a linked slot clears the link
    load_code(16'h0001, 5'd1, 8'h55);
    decode_window(16'hFF80);
    // a second load of a recorded symbol keeps the first code
    load_code(16'hFFF5, 5'd3, 8'hAA);
    encode_symbol(8'hAA);
    encode_symbol(8'hFF);
    encode_symbol(8'h55);
    load_code(16'hFFFF, 5'd16, 8'h80);
    decode_window(16'hFFFF);
    decode_window(16'h7F00);

    // random part, with a stretch free of gaps and stalls in the middle
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet <= (i >= 500 && i < 800);
      random_item();
    end
    in_valid <= 1'b0;
    quiet    <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("items sent: %0d loads, %0d decodes, %0d encodes, %0d unknown commands",
             loads_sent, decodes_sent, encodes_sent, others_sent);
    $display("results compared: %0d, of which %0d pool-full loads; %0d failures",
             results_checked, pool_full_seen, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
